>>> sv/distinct_index_sampler_defines.svh
// Assertion macros used by the checker file of the distinct index sampler.
`ifndef DISTINCT_INDEX_SAMPLER_DEFINES_SVH
`define DISTINCT_INDEX_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dis_pkg.sv
// Types, constants and helper functions of the distinct index sampler.
package dis_pkg;

  localparam int MAX_RING_LOG2 = 11;
  localparam int MAX_RING      = 1 << MAX_RING_LOG2;
  localparam int POS_W         = MAX_RING_LOG2;
  localparam int WEIGHT_W      = 12;
  localparam int RLOG_W        = 4;
  localparam int WORD_W        = 16;
  localparam int BYTE_BITS     = 8;

  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [POS_W-1:0]    slot_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [RLOG_W-1:0]   rlog_t;
  typedef logic [WORD_W-1:0]   word_t;

  typedef enum logic [0:0] {
    CFG_WEIGHT    = 1'b0,
    CFG_RING_LOG2 = 1'b1
  } cfg_idx_e;

  // One write into both maps: position -> slot and slot -> position.
  typedef struct packed {
    logic  en;
    pos_t  pos;
    slot_t slot;
  } map_wr_t;

  function automatic weight_t ring_size(rlog_t rl);
    rlog_t bits;
    bits = (rl > rlog_t'(MAX_RING_LOG2)) ? rlog_t'(MAX_RING_LOG2) : rl;
    return weight_t'(1) << bits;
  endfunction

  function automatic pos_t ring_mask(rlog_t rl);
    return pos_t'(ring_size(rl) - weight_t'(1));
  endfunction

  // Weight clipped to the ring size, and never below one.
  function automatic weight_t eff_weight(weight_t w, rlog_t rl);
    weight_t size;
    weight_t om;
    size = ring_size(rl);
    om   = (w > size) ? size : w;
    if (om == '0) begin
      om = weight_t'(1);
    end
    return om;
  endfunction

endpackage

>>> sv/dis_sparse_set.sv
// Sparse-set memories (position to slot, slot to position) with the post-reset sweep.
module dis_sparse_set (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  dis_pkg::pos_t    rd_pos_i,
  input  dis_pkg::map_wr_t wr_i,
  output logic             busy_o,
  output dis_pkg::slot_t   slot_o,
  output dis_pkg::pos_t    pos_o
);
  import dis_pkg::*;

  slot_t slot_mem [MAX_RING];
  pos_t  pos_mem  [MAX_RING];

  slot_t a_rd_q;
  slot_t a_dly_q;
  pos_t  b_rd_q;
  pos_t  clr_q;
  logic  clr_busy_q;

  // Sweep the slot map once after reset so every entry holds a known value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + pos_t'(1);
      if (clr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      slot_mem[clr_q] <= '0;
    end else if (wr_i.en) begin
      slot_mem[wr_i.pos] <= wr_i.slot;
    end
    if (adv_i) begin
      a_rd_q <= slot_mem[rd_pos_i];
    end
  end

  // Second read chases the slot returned by the first.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pos_mem[wr_i.slot] <= wr_i.pos;
    end
    if (adv_i) begin
      b_rd_q  <= pos_mem[a_rd_q];
      a_dly_q <= a_rd_q;
    end
  end

  assign busy_o = clr_busy_q;
  assign slot_o = a_dly_q;
  assign pos_o  = b_rd_q;

endmodule

>>> sv/distinct_index_sampler.sv
// A word passes the pos1 and pos2 registers; if its position is unmarked, its result is
// registered onto out_valid_o. Throughput: one word per cycle while no result waits; a
// position is marked by a two-read sparse-set lookup and one write, with forwarding from
// the two most recent writes. Reset: weight 19, ring_log2 9, empty vector; the slot map is
// swept after reset; in_ready_o stays low until it ends (configuration writes are taken).
module distinct_index_sampler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dis_pkg::word_t    rand_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dis_pkg::pos_t     position_o,
  output dis_pkg::slot_t    slot_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  dis_pkg::cfg_idx_e cfg_idx_i,
  input  dis_pkg::weight_t  cfg_data_i
);
  import dis_pkg::*;

  weight_t weight_q;
  rlog_t   ring_log2_q;

  logic    adv;
  logic    busy;
  logic    in_xfer;
  logic [BYTE_BITS-1:0] word_hi;
  logic [BYTE_BITS-1:0] word_lo;
  pos_t    in_pos;

  logic    v1_q, v2_q;
  pos_t    pos1_q, pos2_q;
  slot_t   count_q, count_d;
  map_wr_t h1_q, h2_q, wr;

  slot_t   a_mem;
  pos_t    b_mem;
  logic    h1_hit, h2_hit;
  slot_t   a_fwd;
  pos_t    b_fwd;
  logic    used;
  logic    take;
  logic    is_last;

  logic    out_valid_q;
  pos_t    position_q;
  slot_t   slot_q;
  logic    last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= weight_t'(19);
      ring_log2_q <= rlog_t'(9);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT:    weight_q    <= cfg_data_i;
        CFG_RING_LOG2: ring_log2_q <= cfg_data_i[RLOG_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipe moves together; hold it while a result waits.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign word_hi = rand_word_i[WORD_W-1 -: BYTE_BITS];
  assign word_lo = rand_word_i[BYTE_BITS-1:0];
  assign in_pos  = pos_t'({word_hi, word_lo}) & ring_mask(ring_log2_q);

  dis_sparse_set u_set (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .rd_pos_i (in_pos),
    .wr_i     (wr),
    .busy_o   (busy),
    .slot_o   (a_mem),
    .pos_o    (b_mem)
  );

  // Patch the lookups with the writes they missed: h1 missed by both reads, h2 by the first.
  always_comb begin
    h1_hit = h1_q.en && (h1_q.pos == pos2_q);
    h2_hit = h2_q.en && (h2_q.pos == pos2_q);
    if (h1_hit) begin
      a_fwd = h1_q.slot;
    end else if (h2_hit) begin
      a_fwd = h2_q.slot;
    end else begin
      a_fwd = a_mem;
    end
    if (h1_q.en && (h1_q.slot == a_fwd)) begin
      b_fwd = h1_q.pos;
    end else if (h2_hit) begin
      b_fwd = pos2_q;
    end else begin
      b_fwd = b_mem;
    end
    used    = (a_fwd < count_q) && (b_fwd == pos2_q);
    take    = v2_q && !used;
    is_last = ({1'b0, count_q} + weight_t'(1)) >= eff_weight(weight_q, ring_log2_q);
    count_d = is_last ? '0 : count_q + slot_t'(1);
    wr.en   = adv && take;
    wr.pos  = pos2_q;
    wr.slot = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      count_q     <= '0;
      h1_q        <= '0;
      h2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_xfer;
      v2_q        <= v1_q;
      h1_q        <= wr;
      h2_q        <= h1_q;
      out_valid_q <= take;
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos1_q <= in_pos;
      pos2_q <= pos1_q;
      if (take) begin
        position_q <= pos2_q;
        slot_q     <= count_q;
        last_q     <= is_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign slot_o      = slot_q;
  assign last_o      = last_q;

endmodule

>>> sv/dis_checker.sv
// Port-level checks of the distinct index sampler, bound to the top level.
`include "distinct_index_sampler_defines.svh"

module dis_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_ready_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dis_pkg::slot_t    slot_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  dis_pkg::cfg_idx_e cfg_idx_i,
  input  dis_pkg::weight_t  cfg_data_i
);
  import dis_pkg::*;

  weight_t weight_q;
  rlog_t   ring_log2_q;
  slot_t   exp_slot_q;
  logic    last_exp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= weight_t'(19);
      ring_log2_q <= rlog_t'(9);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT:    weight_q    <= cfg_data_i;
        CFG_RING_LOG2: ring_log2_q <= cfg_data_i[RLOG_W-1:0];
        default: ;
      endcase
    end
  end

  // Track the slot the next result must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_slot_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_slot_q <= last_i ? '0 : slot_i + slot_t'(1);
    end
  end

  assign last_exp = ({1'b0, slot_i} + weight_t'(1)) >= eff_weight(weight_q, ring_log2_q);

  `DIS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i,
    "result dropped before transfer")
  `DIS_ASSERT_NOW(a_stall_blocks_input, out_valid_i && !out_ready_i, !in_ready_i,
    "input taken while output stalled")
  `DIS_ASSERT_NOW(a_slot_sequence, out_valid_i, slot_i == exp_slot_q,
    "slot out of sequence")
  `DIS_ASSERT_NOW(a_last_flag, out_valid_i, last_i == last_exp,
    "last flag disagrees with effective weight")

endmodule

bind distinct_index_sampler dis_checker u_dis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .slot_i      (slot_o),
  .last_i      (last_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);
